[hdl/esg_pkg.sv]
// esg_pkg: shared types, widths and register codes for the elastic stress block
// no dependencies

package esg_pkg;

  localparam int unsigned GradW  = 32;
  localparam int unsigned StrW   = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SymW   = GradW + 1;        // g_ij + g_ji
  localparam int unsigned ProdW  = 2 * GradW;        // one g*g product
  localparam int unsigned PsumW  = ProdW + 2;        // sum of three products
  localparam int unsigned E2W    = PsumW - 24 + 1;   // rounded strain plus sym
  localparam int unsigned WW     = E2W + 1;          // doubled lane value
  localparam int unsigned TrW    = WW + 2;           // trace of three lane values
  localparam int unsigned HalfW  = 16;
  localparam int unsigned PaW    = WW + HalfW + 1;
  localparam int unsigned PcW    = TrW + HalfW + 1;
  localparam int unsigned AccW   = 80;
  localparam int unsigned OutShift = 25;

  localparam logic [1:0]      DimReset   = 2'd3;
  localparam logic [1:0]      ModeReset  = 2'd0;
  localparam logic [CfgW-1:0] MuReset    = 32'd5041231;
  localparam logic [CfgW-1:0] LamReset   = 32'd7561846;
  localparam logic [CfgW-1:0] PsLamReset = 32'd4321057;

  localparam logic [1:0] DimTwo    = 2'd2;
  localparam logic [1:0] ModePlane = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIMENSION = 3'd0,
    CFG_MODE      = 3'd1,
    CFG_MU        = 3'd2,
    CFG_LAMBDA    = 3'd3,
    CFG_PS_LAMBDA = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GradW-1:0] grad_00;
    logic signed [GradW-1:0] grad_01;
    logic signed [GradW-1:0] grad_02;
    logic signed [GradW-1:0] grad_10;
    logic signed [GradW-1:0] grad_11;
    logic signed [GradW-1:0] grad_12;
    logic signed [GradW-1:0] grad_20;
    logic signed [GradW-1:0] grad_21;
    logic signed [GradW-1:0] grad_22;
  } grad_t;

  typedef struct packed {
    logic signed [StrW-1:0] stress_00;
    logic signed [StrW-1:0] stress_01;
    logic signed [StrW-1:0] stress_02;
    logic signed [StrW-1:0] stress_10;
    logic signed [StrW-1:0] stress_11;
    logic signed [StrW-1:0] stress_12;
    logic signed [StrW-1:0] stress_20;
    logic signed [StrW-1:0] stress_21;
    logic signed [StrW-1:0] stress_22;
    logic                   saturated;
  } stress_t;

  // per-lane control
  typedef struct packed {
    logic svk;
    logic use_k2;
    logic diag;
    logic used;
  } lane_ctrl_t;

  // moduli split into 16-bit halves
  typedef struct packed {
    logic [HalfW-1:0] mh;
    logic [HalfW-1:0] ml;
    logic [HalfW-1:0] lh;
    logic [HalfW-1:0] ll;
  } coef_t;

endpackage

[hdl/esg_grad_if.sv]
// esg_grad_if: valid/ready channel carrying one displacement gradient item
// depends on esg_pkg

interface esg_grad_if;
  logic           valid;
  logic           ready;
  esg_pkg::grad_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/esg_stress_if.sv]
// esg_stress_if: valid/ready channel carrying one stress tensor item
// depends on esg_pkg

interface esg_stress_if;
  logic             valid;
  logic             ready;
  esg_pkg::stress_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/elastic_stress_from_gradient.sv]
// elastic_stress_from_gradient: top level, config registers, nine lanes and trace merge
// depends on esg_pkg, esg_grad_if, esg_stress_if, esg_lane, esg_merge
//
// Usage:
//  grad_i carries one 3x3 displacement gradient item (signed Q8.24) per
//  valid/ready handshake; stress_o returns one stress item (signed Q16.16,
//  saturated, with a clip flag) for each gradient, in order.
//  Nine lanes, one per stress entry, compute in parallel; a merge stage
//  forms the trace term shared by the diagonal lanes.
//  Each item passes through the five-stage lane pipeline, with every
//  multiplier registered; throughput is one item per cycle while the
//  receiver does not stall stress_o.
//  The cfg port writes dimension, mode and moduli; write only while idle.
//  Reset restores the register defaults and empties the pipeline.
//  When the receiver stalls with a result held, the whole pipeline holds
//  and grad_i.ready drops; items in flight are kept, none are lost.

module elastic_stress_from_gradient (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [esg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [esg_pkg::CfgW-1:0]       cfg_wdata_i,
  esg_grad_if.sink                       grad_i,
  esg_stress_if.source                   stress_o
);

  logic [1:0]               dim_q, mode_q;
  logic [esg_pkg::CfgW-1:0] mu_q, lam_q, pslam_q, lam_sel;
  logic                     svk, dim3, en;
  logic [4:0]               vld_q;
  esg_pkg::coef_t           coef;
  logic signed [esg_pkg::GradW-1:0] g [3][3];
  logic signed [esg_pkg::WW-1:0]    w [3][3];
  logic signed [esg_pkg::StrW-1:0]  res [3][3];
  logic [8:0]                       sat;
  logic signed [esg_pkg::TrW-1:0]   trace_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= esg_pkg::DimReset;
      mode_q  <= esg_pkg::ModeReset;
      mu_q    <= esg_pkg::MuReset;
      lam_q   <= esg_pkg::LamReset;
      pslam_q <= esg_pkg::PsLamReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esg_pkg::CFG_DIMENSION: dim_q   <= cfg_wdata_i[1:0];
        esg_pkg::CFG_MODE:      mode_q  <= cfg_wdata_i[1:0];
        esg_pkg::CFG_MU:        mu_q    <= cfg_wdata_i;
        esg_pkg::CFG_LAMBDA:    lam_q   <= cfg_wdata_i;
        esg_pkg::CFG_PS_LAMBDA: pslam_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // decoded controls and moduli halves
  assign svk     = mode_q[1];
  assign dim3    = (dim_q != esg_pkg::DimTwo);
  assign lam_sel = (mode_q == esg_pkg::ModePlane) ? pslam_q : lam_q;
  assign coef    = '{mh: mu_q[31:16], ml: mu_q[15:0], lh: lam_sel[31:16], ll: lam_sel[15:0]};

  // pipeline advance and valid tracking
  assign en           = !vld_q[4] || stress_o.ready;
  assign grad_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], grad_i.valid};
    end
  end

  // gradient matrix view
  assign g[0][0] = grad_i.data.grad_00;
  assign g[0][1] = grad_i.data.grad_01;
  assign g[0][2] = grad_i.data.grad_02;
  assign g[1][0] = grad_i.data.grad_10;
  assign g[1][1] = grad_i.data.grad_11;
  assign g[1][2] = grad_i.data.grad_12;
  assign g[2][0] = grad_i.data.grad_20;
  assign g[2][1] = grad_i.data.grad_21;
  assign g[2][2] = grad_i.data.grad_22;

  // one lane per stress entry
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [esg_pkg::GradW-1:0] col_a [3];
      logic signed [esg_pkg::GradW-1:0] col_b [3];
      esg_pkg::lane_ctrl_t              ctrl;

      for (genvar k = 0; k < 3; k++) begin : g_k
        assign col_a[k] = g[k][i];
        assign col_b[k] = g[k][j];
      end

      assign ctrl = '{svk: svk, use_k2: dim3, diag: (i == j),
                      used: dim3 || (i < 2 && j < 2)};

      esg_lane u_lane (
        .clk_i   (clk_i),
        .en_i    (en),
        .col_a_i (col_a),
        .col_b_i (col_b),
        .g_ij_i  (g[i][j]),
        .g_ji_i  (g[j][i]),
        .ctrl_i  (ctrl),
        .coef_i  (coef),
        .trace_i (trace_q),
        .w_o     (w[i][j]),
        .res_o   (res[i][j]),
        .sat_o   (sat[i*3+j])
      );
    end
  end

  // trace merge over the diagonal lanes
  esg_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .dim3_i  (dim3),
    .w00_i   (w[0][0]),
    .w11_i   (w[1][1]),
    .w22_i   (w[2][2]),
    .trace_o (trace_q)
  );

  // result item
  assign stress_o.valid = vld_q[4];
  assign stress_o.data  = '{stress_00: res[0][0], stress_01: res[0][1], stress_02: res[0][2],
                            stress_10: res[1][0], stress_11: res[1][1], stress_12: res[1][2],
                            stress_20: res[2][0], stress_21: res[2][1], stress_22: res[2][2],
                            saturated: |sat};

endmodule

[hdl/esg_lane.sv]
// esg_lane: one stress entry lane, strain products through scaled rounding and clip
// depends on esg_pkg

module esg_lane (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [esg_pkg::GradW-1:0]     col_a_i [3],
  input  logic signed [esg_pkg::GradW-1:0]     col_b_i [3],
  input  logic signed [esg_pkg::GradW-1:0]     g_ij_i,
  input  logic signed [esg_pkg::GradW-1:0]     g_ji_i,
  input  esg_pkg::lane_ctrl_t                  ctrl_i,
  input  esg_pkg::coef_t                       coef_i,
  input  logic signed [esg_pkg::TrW-1:0]       trace_i,
  output logic signed [esg_pkg::WW-1:0]        w_o,
  output logic signed [esg_pkg::StrW-1:0]      res_o,
  output logic                                 sat_o
);

  logic signed [esg_pkg::ProdW-1:0] p_q [3];
  logic signed [esg_pkg::SymW-1:0]  sym_q;
  logic signed [esg_pkg::PsumW-1:0] psum;
  logic signed [esg_pkg::E2W-1:0]   e2;
  logic signed [esg_pkg::WW-1:0]    w_d, w_q, w3_q;
  logic signed [esg_pkg::PaW-1:0]   pa_q, pb_q;
  logic signed [esg_pkg::PcW-1:0]   pc_q, pd_q;
  logic signed [esg_pkg::AccW-1:0]  acc;
  logic signed [esg_pkg::AccW-esg_pkg::OutShift-1:0] qv;
  logic signed [esg_pkg::StrW-1:0]  clip;
  logic                             over, under;

  // stage 1: column products and symmetric sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        if (k < 2 || ctrl_i.use_k2) begin
          p_q[k] <= esg_pkg::ProdW'(col_a_i[k]) * esg_pkg::ProdW'(col_b_i[k]);
        end else begin
          p_q[k] <= '0;
        end
      end
      sym_q <= esg_pkg::SymW'(g_ij_i) + esg_pkg::SymW'(g_ji_i);
    end
  end

  // stage 2: rounded green strain (svk mode) or linear strain, doubled lane value
  always_comb begin
    psum = esg_pkg::PsumW'(p_q[0]) + esg_pkg::PsumW'(p_q[1]) + esg_pkg::PsumW'(p_q[2])
         + esg_pkg::PsumW'(25'sh0800000);
    e2   = esg_pkg::E2W'(sym_q) + esg_pkg::E2W'($signed(psum[esg_pkg::PsumW-1:24]));
    if (ctrl_i.svk) begin
      w_d = {e2, 1'b0};
    end else begin
      w_d = esg_pkg::WW'($signed({sym_q, 1'b0}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q  <= w_d;
      w3_q <= w_q;
    end
  end

  assign w_o = w_q;

  // stage 4: split-modulus products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= esg_pkg::PaW'(w3_q) * esg_pkg::PaW'($signed({1'b0, coef_i.mh}));
      pb_q <= esg_pkg::PaW'(w3_q) * esg_pkg::PaW'($signed({1'b0, coef_i.ml}));
      if (ctrl_i.diag) begin
        pc_q <= esg_pkg::PcW'(trace_i) * esg_pkg::PcW'($signed({1'b0, coef_i.lh}));
        pd_q <= esg_pkg::PcW'(trace_i) * esg_pkg::PcW'($signed({1'b0, coef_i.ll}));
      end else begin
        pc_q <= '0;
        pd_q <= '0;
      end
    end
  end

  // stage 5: recombine, round half up, clip
  always_comb begin
    acc = (esg_pkg::AccW'(pa_q) <<< esg_pkg::HalfW) + esg_pkg::AccW'(pb_q)
        + (esg_pkg::AccW'(pc_q) <<< esg_pkg::HalfW) + esg_pkg::AccW'(pd_q)
        + esg_pkg::AccW'(26'sh1000000);
    qv    = acc[esg_pkg::AccW-1:esg_pkg::OutShift];
    over  = qv > $signed(esg_pkg::AccW'(32'sh7fffffff));
    under = qv < $signed(-(esg_pkg::AccW'(33'sh080000000)));
    if (over) begin
      clip = 32'sh7fffffff;
    end else if (under) begin
      clip = 32'sh80000000;
    end else begin
      clip = qv[esg_pkg::StrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= ctrl_i.used ? clip : '0;
      sat_o <= ctrl_i.used & (over | under);
    end
  end

endmodule

[hdl/esg_merge.sv]
// esg_merge: combines the diagonal lanes into the registered trace term
// depends on esg_pkg

module esg_merge (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic                           dim3_i,
  input  logic signed [esg_pkg::WW-1:0]  w00_i,
  input  logic signed [esg_pkg::WW-1:0]  w11_i,
  input  logic signed [esg_pkg::WW-1:0]  w22_i,
  output logic signed [esg_pkg::TrW-1:0] trace_o
);

  logic signed [esg_pkg::TrW-1:0] sum;

  // diagonal sum, halved since every lane carries a doubled value
  always_comb begin
    sum = esg_pkg::TrW'(w00_i) + esg_pkg::TrW'(w11_i)
        + (dim3_i ? esg_pkg::TrW'(w22_i) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trace_o <= sum >>> 1;
    end
  end

endmodule
